### hw/rtl/lusp_pkg.sv
// Shared types, constants and fixed-point helpers for the LU solver.
// No dependencies; used by lu_solve_partial_pivot.
`timescale 1ns / 1ps

package lusp_pkg;

    localparam int MAX_SIZE    = 4;
    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int IDX_W       = $clog2(MAX_SIZE);
    localparam int CNT_W       = $clog2(MAX_SIZE + 1);
    localparam int FAC_DEPTH   = MAX_SIZE * MAX_SIZE;
    localparam int QUO_W       = VALUE_WIDTH + FRAC_BITS;
    localparam int PROD_W      = 2 * VALUE_WIDTH;
    localparam int DCNT_W      = $clog2(QUO_W);

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] element_value;
        logic                          final_element;
    } in_beat_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] solution_value;
        logic [IDX_W-1:0]              solution_index;
        logic [IDX_W-1:0]              original_row;
        logic                          singular_flag;
        logic                          run_end;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PIV,
        ST_SWAP,
        ST_DIV_LD,
        ST_DIV_RUN,
        ST_DIV_WR,
        ST_RD1,
        ST_RD2,
        ST_MUL,
        ST_SUB,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_FACT,
        PH_FWD,
        PH_BACK
    } phase_t;

    // magnitude of a signed value
    function automatic logic [VALUE_WIDTH-1:0] mag_of(input logic signed [VALUE_WIDTH-1:0] a);
        logic [VALUE_WIDTH-1:0] r;
        r = a[VALUE_WIDTH-1] ? (~a + 1'b1) : a;
        return r;
    endfunction

    // signed value from magnitude and sign, saturated
    function automatic logic signed [VALUE_WIDTH-1:0] sat_mag(input logic [QUO_W-1:0] m,
                                                              input logic neg);
        logic [QUO_W-1:0] vmax;
        logic [VALUE_WIDTH-1:0] r;
        vmax = {{(FRAC_BITS+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
        if (neg) begin
            if (m > vmax) r = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
            else          r = ~m[VALUE_WIDTH-1:0] + 1'b1;
        end else begin
            if (m > vmax) r = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
            else          r = m[VALUE_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

### hw/rtl/lu_solve_partial_pivot.sv
// Top level of the LU solver: loader, sequencer, shared divider and multiplier.
// Depends on lusp_pkg.
`timescale 1ns / 1ps

// Linear system solver, A x = b, signed Q16.16, LU with partial pivoting.
// s_ channel: one beat per element, matrix row-major (n*n beats), then the
//   n right-hand side beats; final_element=1 on the last one starts the solve.
//   Extra elements before final_element are dropped.
// m_ channel: n result beats, index 0..n-1, run_end on the last.
// cfg channel: writes matrix_size (0 acts as 1, above 4 acts as 4); always
//   ready, write only while idle. A write restarts loading.
// Throughput: loading takes one beat per cycle. The solve runs on one
//   bit-serial divider (48 steps per quotient) and one 32x32 multiplier
//   used as a multiply-subtract (read, read, multiply, subtract), so a 4x4
//   solve performs 10 divisions and 26 multiply-subtracts, plus pivot
//   scans and swaps. s_ready is low from the final element until the last
//   result beat is taken.
// Pivoting never moves data: ro_reg maps logical rows to stored rows.
// Reset: size 4, load position cleared, loader ready. Stores hold garbage
//   until written. A stalled receiver simply holds the sequencer in the
//   output state; nothing is lost.
module lu_solve_partial_pivot
    import lusp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_beat_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_beat_t              m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_data
);

    // storage
    logic signed [VALUE_WIDTH-1:0] fac_reg [FAC_DEPTH];
    logic signed [VALUE_WIDTH-1:0] rhs_reg [MAX_SIZE];
    logic [IDX_W-1:0]              ro_reg  [MAX_SIZE];

    // control
    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [2:0]       size_reg;
    logic [CNT_W-1:0] ld_row_reg, ld_row_next;
    logic [IDX_W-1:0] ld_col_reg, ld_col_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] pr_reg, pr_next;
    logic [VALUE_WIDTH-1:0] pm_reg, pm_next;
    logic             sing_reg, sing_next;
    logic [DCNT_W-1:0] dcnt_reg;

    // datapath
    logic signed [VALUE_WIDTH-1:0] piv_reg, l_reg, a_reg, b_reg, x_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic                          pneg_reg;
    logic [QUO_W-1:0]              dnum_reg;
    logic [VALUE_WIDTH-1:0]        drem_reg, dden_reg;
    logic                          dneg_reg;

    logic [CNT_W-1:0] n_eff;
    logic [IDX_W-1:0] n_last;
    logic s_acc, m_acc, cfg_acc;

    logic [IDX_W*2-1:0] fac_raddr;
    logic [IDX_W-1:0]   rhs_raddr;
    logic signed [VALUE_WIDTH-1:0] fac_rdata, rhs_rdata;

    logic [VALUE_WIDTH-1:0] m_cur;
    logic                   better;
    logic [VALUE_WIDTH-1:0] pm_best;

    logic [VALUE_WIDTH:0]   rem_sh;
    logic                   rem_ge;
    logic signed [VALUE_WIDTH-1:0] quo;
    logic signed [VALUE_WIDTH-1:0] msub_p;
    logic signed [VALUE_WIDTH:0]   msub_d;
    logic signed [VALUE_WIDTH-1:0] msub;

    assign n_eff = (size_reg == 3'd0) ? CNT_W'(1)
                 : (CNT_W'(size_reg) > CNT_W'(MAX_SIZE)) ? CNT_W'(MAX_SIZE)
                 : CNT_W'(size_reg);
    assign n_last = IDX_W'(n_eff - 1'b1);

    assign s_acc   = s_valid && s_ready;
    assign m_acc   = m_valid && m_ready;
    assign cfg_ready = 1'b1;
    assign cfg_acc = cfg_valid && cfg_ready;

    assign fac_rdata = fac_reg[fac_raddr];
    assign rhs_rdata = rhs_reg[rhs_raddr];

    // pivot compare
    assign m_cur   = mag_of(fac_rdata);
    assign better  = m_cur > pm_reg;
    assign pm_best = better ? m_cur : pm_reg;

    // divider step and result
    assign rem_sh = {drem_reg, dnum_reg[QUO_W-1]};
    assign rem_ge = rem_sh >= {1'b0, dden_reg};
    assign quo    = (dden_reg == '0) ? '0 : sat_mag(dnum_reg, dneg_reg);

    // multiply-subtract tail: truncate, saturate, subtract, saturate
    assign msub_p = sat_mag(prod_reg[PROD_W-1:FRAC_BITS], pneg_reg);
    assign msub_d = {x_reg[VALUE_WIDTH-1], x_reg} - {msub_p[VALUE_WIDTH-1], msub_p};
    always_comb begin
        if (msub_d[VALUE_WIDTH] != msub_d[VALUE_WIDTH-1]) begin
            msub = msub_d[VALUE_WIDTH] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                       : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end else begin
            msub = msub_d[VALUE_WIDTH-1:0];
        end
    end

    // next state and loop counters
    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        ld_row_next = ld_row_reg;
        ld_col_next = ld_col_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        k_next      = k_reg;
        pr_next     = pr_reg;
        pm_next     = pm_reg;
        sing_next   = sing_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_acc) begin
                    if (ld_row_reg <= CNT_W'(n_last)) begin
                        if (ld_col_reg == n_last) begin
                            ld_col_next = '0;
                            ld_row_next = ld_row_reg + 1'b1;
                        end else begin
                            ld_col_next = ld_col_reg + 1'b1;
                        end
                    end else if (ld_row_reg == n_eff) begin
                        if (ld_col_reg == n_last) begin
                            ld_col_next = '0;
                            ld_row_next = ld_row_reg + 1'b1;
                        end else begin
                            ld_col_next = ld_col_reg + 1'b1;
                        end
                    end
                    if (s_data.final_element) begin
                        ld_row_next = '0;
                        ld_col_next = '0;
                        phase_next  = PH_FACT;
                        col_next    = '0;
                        row_next    = '0;
                        pr_next     = '0;
                        pm_next     = '0;
                        sing_next   = 1'b0;
                        state_next  = ST_PIV;
                    end
                end
                if (cfg_acc) begin
                    ld_row_next = '0;
                    ld_col_next = '0;
                end
            end
            ST_PIV: begin
                if (better) begin
                    pm_next = m_cur;
                    pr_next = row_reg;
                end
                if (row_reg == n_last) begin
                    if (pm_best == '0) begin
                        sing_next  = 1'b1;
                        k_next     = '0;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_SWAP;
                    end
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end
            ST_SWAP: begin
                if (col_reg == n_last) begin
                    if (n_last == '0) begin
                        phase_next = PH_BACK;
                        row_next   = n_last;
                        state_next = ST_DIV_LD;
                    end else begin
                        phase_next = PH_FWD;
                        row_next   = IDX_W'(1);
                        k_next     = '0;
                        state_next = ST_RD1;
                    end
                end else begin
                    row_next   = col_reg + 1'b1;
                    state_next = ST_DIV_LD;
                end
            end
            ST_DIV_LD: begin
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                if (dcnt_reg == DCNT_W'(QUO_W - 1)) state_next = ST_DIV_WR;
            end
            ST_DIV_WR: begin
                if (phase_reg == PH_FACT) begin
                    k_next     = col_reg + 1'b1;
                    state_next = ST_RD1;
                end else if (row_reg == '0) begin
                    k_next     = '0;
                    state_next = ST_OUT;
                end else begin
                    row_next   = row_reg - 1'b1;
                    k_next     = row_reg;
                    state_next = ST_RD1;
                end
            end
            ST_RD1: state_next = ST_RD2;
            ST_RD2: state_next = ST_MUL;
            ST_MUL: state_next = ST_SUB;
            ST_SUB: begin
                case (phase_reg)
                    PH_FACT: begin
                        if (k_reg != n_last) begin
                            k_next     = k_reg + 1'b1;
                            state_next = ST_RD1;
                        end else if (row_reg != n_last) begin
                            row_next   = row_reg + 1'b1;
                            state_next = ST_DIV_LD;
                        end else begin
                            col_next   = col_reg + 1'b1;
                            row_next   = col_reg + 1'b1;
                            pr_next    = col_reg + 1'b1;
                            pm_next    = '0;
                            state_next = ST_PIV;
                        end
                    end
                    PH_FWD: begin
                        if (k_reg + 1'b1 != row_reg) begin
                            k_next     = k_reg + 1'b1;
                            state_next = ST_RD1;
                        end else if (row_reg != n_last) begin
                            row_next   = row_reg + 1'b1;
                            k_next     = '0;
                            state_next = ST_RD1;
                        end else begin
                            phase_next = PH_BACK;
                            row_next   = n_last;
                            state_next = ST_DIV_LD;
                        end
                    end
                    default: begin
                        if (k_reg != n_last) begin
                            k_next     = k_reg + 1'b1;
                            state_next = ST_RD1;
                        end else begin
                            state_next = ST_DIV_LD;
                        end
                    end
                endcase
            end
            ST_OUT: begin
                if (m_acc) begin
                    if (k_reg == n_last) begin
                        state_next = ST_LOAD;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // read address selection and handshake outputs
    always_comb begin
        s_ready   = (state_reg == ST_LOAD);
        m_valid   = (state_reg == ST_OUT);
        fac_raddr = {ro_reg[row_reg], col_reg};
        rhs_raddr = ro_reg[row_reg];
        case (state_reg)
            ST_PIV:    fac_raddr = {ro_reg[row_reg], col_reg};
            ST_DIV_LD: fac_raddr = (phase_reg == PH_FACT) ? {ro_reg[row_reg], col_reg}
                                                          : {ro_reg[row_reg], row_reg};
            ST_RD1: begin
                fac_raddr = (phase_reg == PH_FACT) ? {ro_reg[col_reg], k_reg}
                                                   : {ro_reg[row_reg], k_reg};
                rhs_raddr = ro_reg[k_reg];
            end
            ST_RD2:    fac_raddr = {ro_reg[row_reg], k_reg};
            ST_OUT:    rhs_raddr = ro_reg[k_reg];
            default:   fac_raddr = {ro_reg[row_reg], col_reg};
        endcase
    end

    assign m_data.solution_value = sing_reg ? '0 : rhs_rdata;
    assign m_data.solution_index = k_reg;
    assign m_data.original_row   = ro_reg[k_reg];
    assign m_data.singular_flag  = sing_reg;
    assign m_data.run_end        = (k_reg == n_last);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            phase_reg  <= PH_FACT;
            size_reg   <= 3'(MAX_SIZE);
            ld_row_reg <= '0;
            ld_col_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            k_reg      <= '0;
            pr_reg     <= '0;
            pm_reg     <= '0;
            sing_reg   <= 1'b0;
            dcnt_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            ld_row_reg <= ld_row_next;
            ld_col_reg <= ld_col_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            k_reg      <= k_next;
            pr_reg     <= pr_next;
            pm_reg     <= pm_next;
            sing_reg   <= sing_next;
            if (cfg_acc) size_reg <= cfg_data;
            if (state_reg == ST_DIV_RUN) dcnt_reg <= dcnt_reg + 1'b1;
            else                         dcnt_reg <= '0;
        end
    end

    // stores, row order and arithmetic registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_LOAD: begin
                if (s_acc) begin
                    if (ld_row_reg <= CNT_W'(n_last)) begin
                        fac_reg[{ld_row_reg[IDX_W-1:0], ld_col_reg}] <= s_data.element_value;
                    end else if (ld_row_reg == n_eff) begin
                        rhs_reg[ld_col_reg] <= s_data.element_value;
                    end
                    if (s_data.final_element) begin
                        for (int i = 0; i < MAX_SIZE; i++) ro_reg[IDX_W'(i)] <= IDX_W'(i);
                    end
                end
            end
            ST_PIV: begin
                if (better) piv_reg <= fac_rdata;
            end
            ST_SWAP: begin
                if (pr_reg != col_reg) begin
                    ro_reg[col_reg] <= ro_reg[pr_reg];
                    ro_reg[pr_reg]  <= ro_reg[col_reg];
                end
            end
            ST_DIV_LD: begin
                if (phase_reg == PH_FACT) begin
                    dnum_reg <= {mag_of(fac_rdata), {FRAC_BITS{1'b0}}};
                    dden_reg <= mag_of(piv_reg);
                    dneg_reg <= fac_rdata[VALUE_WIDTH-1] ^ piv_reg[VALUE_WIDTH-1];
                end else begin
                    dnum_reg <= {mag_of(rhs_rdata), {FRAC_BITS{1'b0}}};
                    dden_reg <= mag_of(fac_rdata);
                    dneg_reg <= rhs_rdata[VALUE_WIDTH-1] ^ fac_rdata[VALUE_WIDTH-1];
                end
                drem_reg <= '0;
            end
            ST_DIV_RUN: begin
                drem_reg <= rem_ge ? VALUE_WIDTH'(rem_sh - {1'b0, dden_reg})
                                   : rem_sh[VALUE_WIDTH-1:0];
                dnum_reg <= {dnum_reg[QUO_W-2:0], rem_ge};
            end
            ST_DIV_WR: begin
                if (phase_reg == PH_FACT) begin
                    fac_reg[{ro_reg[row_reg], col_reg}] <= quo;
                    l_reg <= quo;
                end else begin
                    rhs_reg[ro_reg[row_reg]] <= quo;
                end
            end
            ST_RD1: begin
                a_reg <= fac_rdata;
                b_reg <= (phase_reg == PH_FACT) ? l_reg : rhs_rdata;
            end
            ST_RD2: begin
                x_reg <= (phase_reg == PH_FACT) ? fac_rdata : rhs_rdata;
            end
            ST_MUL: begin
                prod_reg <= mag_of(a_reg) * mag_of(b_reg);
                pneg_reg <= a_reg[VALUE_WIDTH-1] ^ b_reg[VALUE_WIDTH-1];
            end
            ST_SUB: begin
                if (phase_reg == PH_FACT) fac_reg[{ro_reg[row_reg], k_reg}] <= msub;
                else                      rhs_reg[ro_reg[row_reg]] <= msub;
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    // loader and result channel are never open together
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("loader ready while results pending");

    // a final element closes the loader at once
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_data.final_element) |=> !s_ready)
        else $error("loader still open after final element");

    // last result beat taken reopens the loader
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_acc && m_data.run_end) |=> s_ready)
        else $error("loader not reopened after run end");

    // a singular run reports zero values
    a_sing: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.singular_flag) |-> (m_data.solution_value == '0))
        else $error("nonzero value on singular result");
`endif

endmodule
